/* hw/rtl/prc_pkg.sv */
package prc_pkg;

  localparam int unsigned CoordBits = 32;
  localparam int unsigned IdBits    = 32;
  localparam int unsigned CfgIdxBits = 2;

  localparam logic [CfgIdxBits-1:0] RegLeft   = 2'd0;
  localparam logic [CfgIdxBits-1:0] RegTop    = 2'd1;
  localparam logic [CfgIdxBits-1:0] RegRight  = 2'd2;
  localparam logic [CfgIdxBits-1:0] RegBottom = 2'd3;

  localparam logic OpMove = 1'b0;
  localparam logic OpLine = 1'b1;

  localparam int unsigned ResetRight  = 4095;
  localparam int unsigned ResetBottom = 4095;

endpackage

/* hw/rtl/prc_divider.sv */
// Restoring divider: one quotient bit per cycle.
module prc_divider #(
  parameter int unsigned NumBits = 2 * prc_pkg::CoordBits + 2,
  parameter int unsigned DenBits = prc_pkg::CoordBits + 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [NumBits-1:0] num_i,
  input  logic [DenBits-1:0] den_i,
  output logic               done_o,
  output logic [NumBits-1:0] quot_o,
  output logic [DenBits-1:0] rem_o
);
  localparam int unsigned CntBits = $clog2(NumBits + 1);

  logic [NumBits-1:0] quot_q;
  logic [DenBits:0]   rem_q;
  logic [DenBits-1:0] den_q;
  logic [CntBits-1:0] cnt_q;
  logic               busy_q;
  logic [DenBits:0]   shifted;

  assign shifted = {rem_q[DenBits-1:0], quot_q[NumBits-1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_o <= 1'b0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntBits'(NumBits);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntBits'(1)) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q <= num_i;
      rem_q  <= '0;
      den_q  <= den_i;
    end else if (busy_q) begin
      if (shifted >= {1'b0, den_q}) begin
        rem_q  <= shifted - {1'b0, den_q};
        quot_q <= {quot_q[NumBits-2:0], 1'b1};
      end else begin
        rem_q  <= shifted;
        quot_q <= {quot_q[NumBits-2:0], 1'b0};
      end
    end
  end

  assign quot_o = quot_q;
  assign rem_o  = rem_q[DenBits-1:0];
endmodule

/* hw/rtl/prc_front.sv */
// Classifies vertices and computes the clip parameters of each segment.
module prc_front #(
  parameter int unsigned CoordBits = prc_pkg::CoordBits
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  output logic                          full_o,
  input  logic                          point_op_i,
  input  logic signed [CoordBits-1:0]   point_x_i,
  input  logic signed [CoordBits-1:0]   point_y_i,
  input  logic [prc_pkg::IdBits-1:0]    point_id_i,
  input  logic                          point_phantom_i,
  input  logic signed [CoordBits-1:0]   left_i,
  input  logic signed [CoordBits-1:0]   top_i,
  input  logic signed [CoordBits-1:0]   right_i,
  input  logic signed [CoordBits-1:0]   bottom_i,
  // job towards the back part
  output logic                          job_valid_o,
  input  logic                          job_ready_i,
  output logic                          job_in_o,
  output logic                          job_out_o,
  output logic                          job_cur_o,
  output logic                          job_op_o,
  output logic [prc_pkg::IdBits-1:0]    job_id_o,
  output logic                          job_ph_o,
  output logic signed [CoordBits-1:0]   job_x_o,
  output logic signed [CoordBits-1:0]   job_y_o,
  output logic signed [CoordBits-1:0]   job_x0_o,
  output logic signed [CoordBits-1:0]   job_y0_o,
  output logic signed [CoordBits:0]     job_dx_o,
  output logic signed [CoordBits:0]     job_dy_o,
  output logic [CoordBits+1:0]          job_ni_o,
  output logic [CoordBits+1:0]          job_di_o,
  output logic [CoordBits+1:0]          job_no_o,
  output logic [CoordBits+1:0]          job_dno_o
);
  import prc_pkg::*;

  localparam int unsigned W  = CoordBits + 2;   // clip param width, signed
  localparam int unsigned PW = 2 * W;

  localparam logic [2:0] SIdle = 3'd0;
  localparam logic [2:0] SEdge = 3'd1;
  localparam logic [2:0] SMul  = 3'd2;
  localparam logic [2:0] SCmp  = 3'd3;
  localparam logic [2:0] SOut  = 3'd4;

  logic [2:0] state_q;
  logic [2:0] edge_q;
  logic       hit_q;
  logic       prev_in_q;
  logic signed [CoordBits-1:0] prev_x_q, prev_y_q;

  logic op_q, ph_q, cur_q, fin_q;
  logic [IdBits-1:0] id_q;
  logic signed [CoordBits-1:0] x_q, y_q, x0_q, y0_q;
  logic signed [CoordBits-1:0] l_q, t_q, r_q, b_q;
  logic signed [W-1:0] ni_q, di_q, no_q, dno_q;
  logic signed [W-1:0] p_q, qq_q;
  logic signed [PW-1:0] m1_q, m2_q;
  logic                 mode_q;   // 0 entry candidate, 1 exit candidate
  logic                 fcmp_q;   // final ni/di <= no/dno check

  logic signed [W-1:0] dxw, dyw;
  logic cur_in;
  logic accept;

  assign accept = push_i && !full_o;
  assign full_o = state_q != SIdle;
  assign cur_in = (point_x_i >= left_i) && (point_x_i <= right_i) &&
                  (point_y_i >= top_i) && (point_y_i <= bottom_i);
  assign dxw = W'(x_q) - W'(x0_q);
  assign dyw = W'(y_q) - W'(y0_q);

  // edge selection
  logic signed [W-1:0] ep, eq;
  always_comb begin
    case (edge_q)
      3'd0: begin ep = -dxw; eq = W'(x0_q) - W'(l_q); end
      3'd1: begin ep =  dxw; eq = W'(r_q) - W'(x0_q); end
      3'd2: begin ep = -dyw; eq = W'(y0_q) - W'(t_q); end
      default: begin ep = dyw; eq = W'(b_q) - W'(y0_q); end
    endcase
  end

  // sign of candidate against current bound; cross products registered
  logic signed [W-1:0] cn, cd, bn, bd;
  always_comb begin
    if (fcmp_q) begin
      cn = ni_q; cd = di_q; bn = no_q; bd = dno_q;
    end else if (!mode_q) begin
      cn = -qq_q; cd = -p_q; bn = ni_q; bd = di_q;
    end else begin
      cn = qq_q; cd = p_q; bn = no_q; bd = dno_q;
    end
  end

  logic signed [PW-1:0] diff;
  assign diff = m1_q - m2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= SIdle;
      prev_in_q <= 1'b0;
      prev_x_q  <= '0;
      prev_y_q  <= '0;
      edge_q    <= '0;
      hit_q     <= 1'b0;
      mode_q    <= 1'b0;
      fcmp_q    <= 1'b0;
    end else begin
      case (state_q)
        SIdle: begin
          if (accept) begin
            prev_x_q  <= point_x_i;
            prev_y_q  <= point_y_i;
            prev_in_q <= cur_in;
            edge_q    <= '0;
            fcmp_q    <= 1'b0;
            hit_q     <= 1'b1;
            if (point_op_i == OpMove || (cur_in && prev_in_q)) begin
              state_q <= SOut;
            end else begin
              state_q <= SEdge;
            end
          end
        end
        SEdge: begin
          if (fcmp_q) begin
            state_q <= SMul;
          end else if (edge_q == 3'd4) begin
            fcmp_q  <= 1'b1;
            state_q <= SMul;
          end else if (ep == '0) begin
            if (eq < 0) begin
              hit_q   <= 1'b0;
              state_q <= SOut;
            end
            edge_q <= edge_q + 1'b1;
          end else begin
            mode_q  <= ep > 0;
            state_q <= SMul;
          end
        end
        SMul: state_q <= SCmp;
        SCmp: begin
          if (fcmp_q) begin
            if (diff > 0) hit_q <= 1'b0;
            state_q <= SOut;
          end else begin
            edge_q  <= edge_q + 1'b1;
            state_q <= SEdge;
          end
        end
        SOut: begin
          if (job_ready_i) state_q <= SIdle;
        end
        default: state_q <= SIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      SIdle: begin
        if (accept) begin
          op_q <= point_op_i; ph_q <= point_phantom_i;
          id_q <= point_id_i; x_q <= point_x_i; y_q <= point_y_i;
          x0_q <= prev_x_q; y0_q <= prev_y_q;
          cur_q <= cur_in; fin_q <= prev_in_q;
          l_q <= left_i; t_q <= top_i; r_q <= right_i; b_q <= bottom_i;
          ni_q <= '0; di_q <= W'(1); no_q <= W'(1); dno_q <= W'(1);
        end
      end
      SEdge: begin
        p_q <= ep; qq_q <= eq;
      end
      SMul: begin
        // cross-multiply candidate and bound as signed products
        m1_q <= PW'(cn) * PW'(bd);
        m2_q <= PW'(bn) * PW'(cd);
      end
      SCmp: begin
        if (!fcmp_q) begin
          if (!mode_q && diff > 0) begin
            ni_q <= -qq_q; di_q <= -p_q;
          end else if (mode_q && diff < 0) begin
            no_q <= qq_q; dno_q <= p_q;
          end
        end
      end
      default: ;
    endcase
  end

  assign job_valid_o = state_q == SOut;
  assign job_in_o    = hit_q && op_q == OpLine && !(cur_q && fin_q) && !fin_q;
  assign job_out_o   = hit_q && op_q == OpLine && !(cur_q && fin_q) && !cur_q;
  assign job_cur_o   = cur_q && (op_q == OpMove || fin_q || hit_q);
  assign job_op_o    = op_q;
  assign job_id_o    = id_q;
  assign job_ph_o    = ph_q;
  assign job_x_o     = x_q;
  assign job_y_o     = y_q;
  assign job_x0_o    = x0_q;
  assign job_y0_o    = y0_q;
  assign job_dx_o    = dxw[CoordBits:0];
  assign job_dy_o    = dyw[CoordBits:0];
  assign job_ni_o    = ni_q;
  assign job_di_o    = di_q;
  assign job_no_o    = no_q;
  assign job_dno_o   = dno_q;
endmodule

/* hw/rtl/prc_back.sv */
// Computes clip points through a shared divider and drives the result queue.
module prc_back #(
  parameter int unsigned CoordBits = prc_pkg::CoordBits
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          job_valid_i,
  output logic                          job_ready_o,
  input  logic                          job_in_i,
  input  logic                          job_out_i,
  input  logic                          job_cur_i,
  input  logic                          job_op_i,
  input  logic [prc_pkg::IdBits-1:0]    job_id_i,
  input  logic                          job_ph_i,
  input  logic signed [CoordBits-1:0]   job_x_i,
  input  logic signed [CoordBits-1:0]   job_y_i,
  input  logic signed [CoordBits-1:0]   job_x0_i,
  input  logic signed [CoordBits-1:0]   job_y0_i,
  input  logic signed [CoordBits:0]     job_dx_i,
  input  logic signed [CoordBits:0]     job_dy_i,
  input  logic [CoordBits+1:0]          job_ni_i,
  input  logic [CoordBits+1:0]          job_di_i,
  input  logic [CoordBits+1:0]          job_no_i,
  input  logic [CoordBits+1:0]          job_dno_i,
  output logic                          empty_o,
  input  logic                          pop_i,
  output logic                          out_op_o,
  output logic signed [CoordBits-1:0]   out_x_o,
  output logic signed [CoordBits-1:0]   out_y_o,
  output logic [prc_pkg::IdBits-1:0]    out_id_o,
  output logic                          out_phantom_o,
  output logic                          out_last_o
);
  import prc_pkg::*;

  localparam int unsigned W   = CoordBits + 2;
  localparam int unsigned NB  = 2 * W;
  localparam int unsigned RW  = 3 + 2 * CoordBits + IdBits;

  localparam logic [2:0] SIdle = 3'd0;
  localparam logic [2:0] SPick = 3'd1;
  localparam logic [2:0] SMul  = 3'd2;
  localparam logic [2:0] SDiv  = 3'd3;
  localparam logic [2:0] SRnd  = 3'd4;
  localparam logic [2:0] SPush = 3'd5;

  logic [2:0] state_q;
  logic [1:0] step_q;    // 0 in.x 1 in.y 2 out.x 3 out.y
  logic need_in_q, need_out_q, cur_q;
  logic op_q, ph_q;
  logic [IdBits-1:0] id_q;
  logic signed [CoordBits-1:0] x_q, y_q, x0_q, y0_q, px_q, py_q;
  logic signed [CoordBits:0] dx_q, dy_q;
  logic [W-1:0] ni_q, di_q, no_q, dno_q;

  // result queue, two entries
  logic [RW-1:0] fifo_q [2];
  logic          wp_q, rp_q;
  logic [1:0]    cnt_q;
  logic          fpush;
  logic [RW-1:0] fdata;

  logic signed [CoordBits:0] dv;
  logic signed [CoordBits-1:0] av;
  logic [W-1:0] nn, dd;
  always_comb begin
    dv = step_q[0] ? dy_q : dx_q;
    av = step_q[0] ? y0_q : x0_q;
    nn = step_q[1] ? no_q : ni_q;
    dd = step_q[1] ? dno_q : di_q;
  end

  logic [NB-1:0] prod_q;
  logic          neg_q;
  logic          zero_q;
  logic          dstart, ddone;
  logic [NB-1:0] quot;
  logic [W-1:0]  rem;

  prc_divider #(.NumBits(NB), .DenBits(W)) u_div (
    .clk_i, .rst_ni, .start_i(dstart), .num_i(prod_q), .den_i(dd),
    .done_o(ddone), .quot_o(quot), .rem_o(rem)
  );
  assign dstart = state_q == SMul && !zero_q;

  logic signed [W:0] base;
  logic [W:0] rem2;
  logic signed [W:0] rnd;
  always_comb begin
    rem2 = {rem, 1'b0};
    base = neg_q ? (W+1)'(av) - (W+1)'(quot[W-1:0])
                 : (W+1)'(av) + (W+1)'(quot[W-1:0]);
    rnd = base;
    if (rem2 > (W+1)'(dd) || (rem2 == (W+1)'(dd) && (neg_q ? base <= 0 : base >= 0)))
      rnd = neg_q ? base - 1 : base + 1;
  end

  logic room;
  assign room = cnt_q != 2'd2;
  assign job_ready_o = state_q == SIdle;

  logic more;   // another result follows the one being pushed
  always_comb begin
    fpush = 1'b0;
    fdata = '0;
    more  = 1'b0;
    if (state_q == SPush && room) begin
      fpush = 1'b1;
      if (step_q == 2'd1 && need_in_q) begin
        more  = need_out_q || cur_q;
        fdata = {OpMove, px_q, py_q, {IdBits{1'b0}}, 1'b1, !more};
      end else if (step_q == 2'd3) begin
        fdata = {OpLine, px_q, py_q, {IdBits{1'b0}}, 1'b1, 1'b1};
      end else begin
        fdata = {op_q, x_q, y_q, id_q, ph_q, 1'b1};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      step_q  <= '0;
      wp_q    <= 1'b0;
      rp_q    <= 1'b0;
      cnt_q   <= '0;
    end else begin
      case (state_q)
        SIdle: begin
          if (job_valid_i) begin
            if (job_in_i) begin
              step_q <= 2'd0; state_q <= SPick;
            end else if (job_out_i) begin
              step_q <= 2'd2; state_q <= SPick;
            end else if (job_cur_i) begin
              step_q <= 2'd0; state_q <= SPush;
            end
          end
        end
        SMul: state_q <= zero_q ? SRnd : SDiv;
        SDiv: if (ddone) state_q <= SRnd;
        SRnd: begin
          if (!step_q[0]) begin
            step_q <= step_q + 1'b1; state_q <= SPick;
          end else begin
            state_q <= SPush;
          end
        end
        SPick: state_q <= SMul;
        SPush: begin
          if (room) begin
            if (step_q == 2'd1 && need_in_q && need_out_q) begin
              step_q <= 2'd2; state_q <= SPick;
            end else if (step_q == 2'd1 && need_in_q && cur_q) begin
              step_q <= 2'd0; state_q <= SPush;
            end else begin
              state_q <= SIdle;
            end
          end
        end
        default: state_q <= SIdle;
      endcase
      if (fpush) wp_q <= !wp_q;
      if (pop_i && !empty_o) rp_q <= !rp_q;
      cnt_q <= cnt_q + {1'b0, fpush} - {1'b0, pop_i && !empty_o};
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == SIdle && job_valid_i) begin
      need_in_q <= job_in_i; need_out_q <= job_out_i; cur_q <= job_cur_i;
      op_q <= job_op_i; ph_q <= job_ph_i; id_q <= job_id_i;
      x_q <= job_x_i; y_q <= job_y_i; x0_q <= job_x0_i; y0_q <= job_y0_i;
      dx_q <= job_dx_i; dy_q <= job_dy_i;
      ni_q <= job_ni_i; di_q <= job_di_i; no_q <= job_no_i; dno_q <= job_dno_i;
    end
    if (state_q == SPush && room && step_q == 2'd1 && need_in_q && !need_out_q && cur_q)
      need_in_q <= 1'b0;
    if (state_q == SPick) begin
      prod_q <= NB'(dv < 0 ? -dv : dv) * NB'(nn);
      neg_q  <= dv < 0;
      zero_q <= dv == 0 || nn == '0;
    end
    if (state_q == SRnd) begin
      if (!step_q[0]) px_q <= zero_q ? av : rnd[CoordBits-1:0];
      else            py_q <= zero_q ? av : rnd[CoordBits-1:0];
    end
    if (fpush) fifo_q[wp_q] <= fdata;
  end

  assign empty_o = cnt_q == 2'd0;
  assign {out_op_o, out_x_o, out_y_o, out_id_o, out_phantom_o, out_last_o} = fifo_q[rp_q];
endmodule

/* hw/rtl/polyline_rect_clip.sv */
// Polyline rectangle clipper. Takes one vertex at a time: the front part runs
// the four boundary tests of a line-to segment, the back part computes each clip
// coordinate with a 68-step restoring divide plus set-up and rounding, and a
// plain vertex passes through the front SOut state and the back SPush state to
// the result queue. Front and back are decoupled by a one-job hand-off; two
// results may wait in the output queue.
module polyline_rect_clip #(
  parameter int unsigned CoordBits = prc_pkg::CoordBits
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [prc_pkg::CfgIdxBits-1:0] cfg_idx_i,
  input  logic [CoordBits-1:0]        cfg_data_i,
  input  logic                        push,
  output logic                        full,
  input  logic                        point_op_i,
  input  logic signed [CoordBits-1:0] point_x_i,
  input  logic signed [CoordBits-1:0] point_y_i,
  input  logic [prc_pkg::IdBits-1:0]  point_id_i,
  input  logic                        point_phantom_i,
  output logic                        empty,
  input  logic                        pop,
  output logic                        out_op_o,
  output logic signed [CoordBits-1:0] out_x_o,
  output logic signed [CoordBits-1:0] out_y_o,
  output logic [prc_pkg::IdBits-1:0]  out_id_o,
  output logic                        out_phantom_o,
  output logic                        out_last_o
);
  import prc_pkg::*;

  logic signed [CoordBits-1:0] left_q, top_q, right_q, bottom_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q   <= '0;
      top_q    <= '0;
      right_q  <= CoordBits'(ResetRight);
      bottom_q <= CoordBits'(ResetBottom);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegLeft:   left_q   <= cfg_data_i;
        RegTop:    top_q    <= cfg_data_i;
        RegRight:  right_q  <= cfg_data_i;
        RegBottom: bottom_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic jv, jr, jin, jout, jcur, jop, jph;
  logic [IdBits-1:0] jid;
  logic signed [CoordBits-1:0] jx, jy, jx0, jy0;
  logic signed [CoordBits:0] jdx, jdy;
  logic [CoordBits+1:0] jni, jdi, jno, jdno;

  prc_front #(.CoordBits(CoordBits)) u_front (
    .clk_i, .rst_ni, .push_i(push), .full_o(full),
    .point_op_i, .point_x_i, .point_y_i, .point_id_i, .point_phantom_i,
    .left_i(left_q), .top_i(top_q), .right_i(right_q), .bottom_i(bottom_q),
    .job_valid_o(jv), .job_ready_i(jr), .job_in_o(jin), .job_out_o(jout),
    .job_cur_o(jcur), .job_op_o(jop), .job_id_o(jid), .job_ph_o(jph),
    .job_x_o(jx), .job_y_o(jy), .job_x0_o(jx0), .job_y0_o(jy0),
    .job_dx_o(jdx), .job_dy_o(jdy), .job_ni_o(jni), .job_di_o(jdi),
    .job_no_o(jno), .job_dno_o(jdno)
  );

  prc_back #(.CoordBits(CoordBits)) u_back (
    .clk_i, .rst_ni, .job_valid_i(jv), .job_ready_o(jr), .job_in_i(jin),
    .job_out_i(jout), .job_cur_i(jcur), .job_op_i(jop), .job_id_i(jid),
    .job_ph_i(jph), .job_x_i(jx), .job_y_i(jy), .job_x0_i(jx0), .job_y0_i(jy0),
    .job_dx_i(jdx), .job_dy_i(jdy), .job_ni_i(jni), .job_di_i(jdi),
    .job_no_i(jno), .job_dno_i(jdno), .empty_o(empty), .pop_i(pop),
    .out_op_o, .out_x_o, .out_y_o, .out_id_o, .out_phantom_o, .out_last_o
  );
endmodule

/* hw/rtl/prc_checker.sv */
module prc_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic push,
  input logic full,
  input logic empty,
  input logic pop,
  input logic out_last_o,
  input logic out_phantom_o,
  input logic [31:0] out_id_o
);
  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |=> empty)
    else $error("results present in reset");
  a_push_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !full |=> full) else $error("not busy after accept");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty) else $error("result lost");
  a_gen_ph: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !out_last_o |-> out_phantom_o && out_id_o == '0)
    else $error("leading result not a clip point");
endmodule

bind polyline_rect_clip prc_checker u_prc_checker (
  .clk_i, .rst_ni, .push, .full, .empty, .pop, .out_last_o, .out_phantom_o,
  .out_id_o
);

/* tb/tb.sv */
`timescale 1ns / 100ps

module tb;
  import prc_pkg::*;

  typedef struct packed {
    logic        op;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] id;
    logic        ph;
    logic        last;
  } vertex_t;

  localparam longint CoordMin = -64'sd2147483648;
  localparam longint CoordMax = 64'sd2147483647;
  localparam int     Drain    = 400;
  localparam int     Limit    = 6000000;

  class clip_scoreboard;
    longint    lft, top, rgt, bot;
    longint    last_x, last_y;
    bit        last_in;
    vertex_t   due[$];
    int        errors;

    function new();
      lft = 0; top = 0; rgt = ResetRight; bot = ResetBottom;
      last_x = 0; last_y = 0; last_in = 0; errors = 0;
    endfunction

    function void set_reg(logic [CfgIdxBits-1:0] idx, logic signed [31:0] v);
      case (idx)
        RegLeft:   lft = v;
        RegTop:    top = v;
        RegRight:  rgt = v;
        RegBottom: bot = v;
        default: ;
      endcase
    endfunction

    function bit in_rect(longint x, longint y);
      return x >= lft && x <= rgt && y >= top && y <= bot;
    endfunction

    function logic [63:0] mag(longint v);
      return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    // sign of n1/d1 - n2/d2, denominators positive
    function int frac_cmp(longint n1, longint d1, longint n2, longint d2);
      int s1, s2, c;
      logic [127:0] a, b;
      s1 = (n1 > 0) - (n1 < 0);
      s2 = (n2 > 0) - (n2 < 0);
      if (s1 != s2) return s1 < s2 ? -1 : 1;
      if (s1 == 0) return 0;
      a = {64'd0, mag(n1)} * {64'd0, 64'(d2)};
      b = {64'd0, mag(n2)} * {64'd0, 64'(d1)};
      c = a < b ? -1 : (a > b ? 1 : 0);
      return s1 > 0 ? c : -c;
    endfunction

    // rounds half away from zero
    function longint lerp_round(longint a, longint dv, longint n, longint d);
      logic [127:0] prod, q, r;
      longint base;
      if (dv == 0 || n == 0) return a;
      prod = {64'd0, mag(dv)} * {64'd0, 64'(n)};
      q = prod / {64'd0, 64'(d)};
      r = prod % {64'd0, 64'(d)};
      if (dv > 0) begin
        base = a + longint'(q[63:0]);
        if (2 * r > d || (2 * r == d && base >= 0)) base++;
      end else begin
        base = a - longint'(q[63:0]);
        if (2 * r > d || (2 * r == d && base <= 0)) base--;
      end
      return base;
    endfunction

    function bit bound(longint p, longint q, inout longint ni, inout longint di,
                       inout longint no, inout longint dno);
      if (p == 0) return q >= 0;
      if (p < 0) begin
        if (frac_cmp(-q, -p, ni, di) > 0) begin
          ni = -q; di = -p;
        end
      end else if (frac_cmp(q, p, no, dno) < 0) begin
        no = q; dno = p;
      end
      return 1;
    endfunction

    function void push_due(logic op, longint x, longint y, logic [31:0] id, logic ph);
      vertex_t v;
      v = '{op: op, x: x[31:0], y: y[31:0], id: id, ph: ph, last: 1'b0};
      due.insert(due.size(), v);
    endfunction

    function void note_item(logic op, logic signed [31:0] xi, logic signed [31:0] yi,
                            logic [31:0] id, logic ph);
      longint x, y, dx, dy, ni, di, no, dno;
      bit cur, hit;
      int n0;
      x = xi; y = yi;
      dx = x - last_x; dy = y - last_y;
      ni = 0; di = 1; no = 1; dno = 1;
      cur = in_rect(x, y);
      n0 = due.size();
      if (op == OpMove) begin
        if (cur) push_due(op, x, y, id, ph);
      end else if (cur && last_in) begin
        push_due(op, x, y, id, ph);
      end else begin
        hit = bound(-dx, last_x - lft, ni, di, no, dno);
        if (hit) hit = bound(dx, rgt - last_x, ni, di, no, dno);
        if (hit) hit = bound(-dy, last_y - top, ni, di, no, dno);
        if (hit) hit = bound(dy, bot - last_y, ni, di, no, dno);
        if (hit) hit = frac_cmp(ni, di, no, dno) <= 0;
        if (hit) begin
          if (!last_in)
            push_due(OpMove, lerp_round(last_x, dx, ni, di),
                     lerp_round(last_y, dy, ni, di), '0, 1'b1);
          if (cur) push_due(op, x, y, id, ph);
          else push_due(OpLine, lerp_round(last_x, dx, no, dno),
                        lerp_round(last_y, dy, no, dno), '0, 1'b1);
        end
      end
      if (due.size() > n0) due[due.size() - 1].last = 1'b1;
      last_x = x; last_y = y; last_in = cur;
    endfunction

    function void check(vertex_t got);
      vertex_t exp_v;
      if (due.size() == 0) begin
        $display("%0t: unexpected item %p", $time, got);
        errors++;
        return;
      end
      exp_v = due.pop_front();
      if (got.op !== exp_v.op) begin
        $display("%0t: op exp %0d got %0d", $time, exp_v.op, got.op); errors++;
      end
      if (got.x !== exp_v.x) begin
        $display("%0t: x exp %0d got %0d", $time, $signed(exp_v.x), $signed(got.x)); errors++;
      end
      if (got.y !== exp_v.y) begin
        $display("%0t: y exp %0d got %0d", $time, $signed(exp_v.y), $signed(got.y)); errors++;
      end
      if (got.id !== exp_v.id) begin
        $display("%0t: id exp %h got %h", $time, exp_v.id, got.id); errors++;
      end
      if (got.ph !== exp_v.ph) begin
        $display("%0t: phantom exp %0d got %0d", $time, exp_v.ph, got.ph); errors++;
      end
      if (got.last !== exp_v.last) begin
        $display("%0t: last exp %0d got %0d", $time, exp_v.last, got.last); errors++;
      end
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CfgIdxBits-1:0] cfg_idx_i = '0;
  logic [31:0]           cfg_data_i = '0;
  logic                  push = 1'b0;
  logic                  full;
  logic                  point_op_i = 1'b0;
  logic signed [31:0]    point_x_i = '0;
  logic signed [31:0]    point_y_i = '0;
  logic [31:0]           point_id_i = '0;
  logic                  point_phantom_i = 1'b0;
  logic                  empty;
  logic                  pop = 1'b0;
  logic                  out_op_o;
  logic signed [31:0]    out_x_o;
  logic signed [31:0]    out_y_o;
  logic [31:0]           out_id_o;
  logic                  out_phantom_o;
  logic                  out_last_o;

  clip_scoreboard sb = new();
  bit  send_quiet;
  bit  recv_quiet;
  int  cycles;
  longint r_lft = 0, r_top = 0, r_rgt = ResetRight, r_bot = ResetBottom;

  polyline_rect_clip i_dut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > Limit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always begin
    int gap;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if ($urandom_range(0, 99) == 0) recv_quiet = !recv_quiet;
      gap = recv_quiet ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      pop <= 1'b1;
      do @(posedge clk_i); while (empty);
      sb.check('{op: out_op_o, x: out_x_o, y: out_y_o, id: out_id_o,
                 ph: out_phantom_o, last: out_last_o});
    end
  end

  task automatic send(logic op, longint x, longint y, logic [31:0] id, logic ph);
    int gap;
    gap = send_quiet ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push            <= 1'b1;
    point_op_i      <= op;
    point_x_i       <= x[31:0];
    point_y_i       <= y[31:0];
    point_id_i      <= id;
    point_phantom_i <= ph;
    do @(posedge clk_i); while (full);
    sb.note_item(op, x[31:0], y[31:0], id, ph);
  endtask

  // holds the sender until the block is idle
  task automatic settle();
    push <= 1'b0;
    while (sb.due.size() != 0) @(posedge clk_i);
    repeat (Drain) @(posedge clk_i);
  endtask

  task automatic set_rect(longint l, longint t, longint r, longint b);
    logic [CfgIdxBits-1:0] idx [4];
    longint vals [4];
    idx = '{RegLeft, RegTop, RegRight, RegBottom};
    vals = '{l, t, r, b};
    settle();
    for (int i = 0; i < 4; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= idx[i];
      cfg_data_i <= vals[i][31:0];
      @(posedge clk_i);
      sb.set_reg(idx[i], vals[i][31:0]);
    end
    cfg_we_i <= 1'b0;
    r_lft = l; r_top = t; r_rgt = r; r_bot = b;
  endtask

  function automatic longint pick_coord(longint lo, longint hi);
    longint span, w, v;
    logic [63:0] rnd;
    if (hi < lo) begin
      v = lo; lo = hi; hi = v;
    end
    case ($urandom_range(0, 9))
      0: return longint'($signed($urandom));
      1: return $urandom_range(0, 1) ? CoordMin : CoordMax;
      default: begin
        span = (hi - lo) / 4 + 8;
        w = hi - lo + 2 * span + 1;
        rnd = {$urandom, $urandom};
        v = lo - span + longint'(rnd % 64'(w));
        if (v < CoordMin) v = CoordMin;
        if (v > CoordMax) v = CoordMax;
        return v;
      end
    endcase
  endfunction

  task automatic random_items(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 49) == 0) send_quiet = !send_quiet;
      send($urandom_range(0, 4) == 0 ? OpMove : OpLine,
           pick_coord(r_lft, r_rgt), pick_coord(r_top, r_bot),
           $urandom, $urandom_range(0, 1));
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // first line-to starts from the origin, judged outside
    send(OpLine, 100, 100, 32'h1, 1'b0);
    send(OpLine, 200, 300, 32'h2, 1'b0);
    send(OpMove, 5000, 5000, 32'h3, 1'b0);
    send(OpLine, 2000, 2000, 32'h4, 1'b0);
    send(OpLine, 5000, -10, 32'hffff_ffff, 1'b1);
    send(OpLine, -10, 5000, 32'h5, 1'b0);
    send(OpLine, 6000, 6000, 32'h6, 1'b0);
    send(OpMove, CoordMin, CoordMax, 32'h7, 1'b1);
    send(OpLine, CoordMax, CoordMin, 32'h8, 1'b0);
    send(OpLine, CoordMax, CoordMin, 32'h9, 1'b0);
    send(OpMove, 4095, 4095, 32'h0, 1'b1);
    send(OpLine, 4095, 4095, 32'ha, 1'b1);
    send(OpMove, -1, 1, 32'hb, 1'b0);
    send(OpLine, 1, -1, 32'hc, 1'b0);
    send(OpMove, -3, 0, 32'hd, 1'b0);
    send(OpLine, 4098, 1, 32'he, 1'b0);
    send(OpLine, 4098, 5000, 32'hf, 1'b0);
    send(OpLine, CoordMin, CoordMin, 32'h8000_0000, 1'b0);
    send(OpLine, CoordMax, CoordMax, 32'h7fff_ffff, 1'b1);
    send(OpMove, 0, 0, 32'h10, 1'b0);
    send(OpLine, 4095, 0, 32'h11, 1'b0);

    random_items(240);
    settle();
    random_items(200);
    set_rect(-50, -50, 50, 50);
    random_items(240);
    set_rect(CoordMin, CoordMin, CoordMax, CoordMax);
    random_items(240);
    set_rect(10, 0, 9, 100);
    random_items(120);
    set_rect(7, 7, 7, 7);
    random_items(150);
    set_rect(CoordMax, CoordMin, CoordMax, CoordMax);
    random_items(120);
    begin
      longint a, b;
      a = longint'($signed($urandom));
      b = longint'($signed($urandom));
      set_rect(a < b ? a : b, -100000, a < b ? b : a, 300);
    end
    random_items(240);
    set_rect(-1000, 200, 3000, 900);
    random_items(240);
    // registers change with the inside flag left over
    set_rect(0, 0, ResetRight, ResetBottom);
    random_items(160);

    push <= 1'b0;
    while (sb.due.size() != 0) @(posedge clk_i);
    repeat (Drain) @(posedge clk_i);
    if (sb.errors == 0 && sb.due.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
